[sv/swmms_pkg.sv]
package swmms_pkg;

   // Window capacity and sample width
   localparam int MAX_WINDOW  = 1024;
   localparam int SAMPLE_BITS = 32;

   // Configuration register width and reset value
   localparam int CFG_BITS = 11;
   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(2);

   // Positions are kept modulo 2*MAX_WINDOW, which covers every age that is checked
   localparam int POS_BITS = $clog2(MAX_WINDOW) + 1;

   // One candidate held by a cell
   typedef struct packed {
      logic                   valid;
      logic [SAMPLE_BITS-1:0] value;
      logic [POS_BITS-1:0]    pos;
   } entry_type;

   // Per-chain command, shared by every cell of the chain
   typedef struct packed {
      logic                   clear;
      logic                   pop;
      logic                   push;
      logic [SAMPLE_BITS-1:0] sample;
      logic [POS_BITS-1:0]    now;
   } cell_ctl_type;

   // What the controller sees of a chain
   typedef struct packed {
      entry_type              first;
      entry_type              second;
      logic [SAMPLE_BITS-1:0] head_next;
   } chain_status_type;

endpackage

[sv/swmms_if.sv]
// Sample channel
interface swmms_req_if;
   logic                               valid;
   logic                               ready;
   logic [swmms_pkg::SAMPLE_BITS-1:0]  sample;
   logic                               last_sample;

   modport source (output valid, sample, last_sample, input ready);
   modport sink   (input valid, sample, last_sample, output ready);
endinterface

// Result channel
interface swmms_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [swmms_pkg::SAMPLE_BITS-1:0]  max_spread;
   logic                               found;

   modport source (output valid, max_spread, found, input ready);
   modport sink   (input valid, max_spread, found, output ready);
endinterface

// Window length register write channel
interface swmms_csr_if;
   logic                               valid;
   logic                               ready;
   logic [swmms_pkg::CFG_BITS-1:0]     window_length;

   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface

[sv/sliding_window_max_spread.sv]
// A last sample passes the pending register and spread stage into the result register.
// Throughput: one sample per cycle, set by the two cell rows, which retire one front
//   candidate and append the new sample in the same cycle. A window shrink holds a sample
//   while more than one candidate must be retired from a queue front; a sample also stalls
//   while a finished last sample waits on a result that rsp_ch has not yet taken.
// Reset: synchronous, clears all queues and sequence state, window_length returns to 2.
module sliding_window_max_spread (
   input  logic          clock,
   input  logic          reset,
   swmms_req_if.sink     req_ch,
   swmms_rsp_if.source   rsp_ch,
   swmms_csr_if.sink     csr_ch
);

   localparam int SB = swmms_pkg::SAMPLE_BITS;
   localparam int PB = swmms_pkg::POS_BITS;

   // Configuration
   logic [swmms_pkg::CFG_BITS-1:0] win_ff;
   logic [PB-1:0]                  win_eff;

   // Pending item and sequence state
   logic          pend_ff;
   logic [SB-1:0] pend_sample_ff;
   logic          pend_last_ff;
   logic [PB-1:0] pos_ff;
   logic          multi_ff;

   // Spread stage
   logic          b_valid_ff;
   logic          b_last_ff;
   logic          b_multi_ff;
   logic [SB-1:0] b_spread_ff;
   logic [SB-1:0] best_ff;
   logic [SB-1:0] best_in;

   // Result register
   logic          rsp_valid_ff;
   logic [SB-1:0] rsp_spread_ff;
   logic          rsp_found_ff;

   swmms_pkg::cell_ctl_type     max_ctl;
   swmms_pkg::cell_ctl_type     min_ctl;
   swmms_pkg::chain_status_type max_st;
   swmms_pkg::chain_status_type min_st;

   logic          max_exp0;
   logic          max_exp1;
   logic          min_exp0;
   logic          min_exp1;
   logic          deep;
   logic          b_stall;
   logic          a_done;
   logic          accept;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= swmms_pkg::CFG_RESET;
      end else if (csr_ch.valid) begin
         win_ff <= csr_ch.window_length;
      end
   end

   // Effective window: zero counts as one, capped at the row length
   always_comb begin
      if (win_ff == '0) begin
         win_eff = PB'(1);
      end else if (int'(win_ff) > swmms_pkg::MAX_WINDOW) begin
         win_eff = PB'(swmms_pkg::MAX_WINDOW);
      end else begin
         win_eff = PB'(win_ff);
      end
   end

   // Expiry of the two oldest candidates of each row
   assign max_exp0 = max_st.first.valid  & ((pos_ff - max_st.first.pos)  >= win_eff);
   assign max_exp1 = max_st.second.valid & ((pos_ff - max_st.second.pos) >= win_eff);
   assign min_exp0 = min_st.first.valid  & ((pos_ff - min_st.first.pos)  >= win_eff);
   assign min_exp1 = min_st.second.valid & ((pos_ff - min_st.second.pos) >= win_eff);
   assign deep     = max_exp1 | min_exp1;

   assign b_stall = b_valid_ff & b_last_ff & rsp_valid_ff & ~rsp_ch.ready;
   assign a_done  = pend_ff & ~deep & ~b_stall;
   assign accept  = req_ch.valid & req_ch.ready;

   assign req_ch.ready = ~pend_ff | a_done;

   // Row commands
   always_comb begin
      max_ctl.clear  = a_done & pend_last_ff;
      max_ctl.pop    = pend_ff & max_exp0;
      max_ctl.push   = a_done;
      max_ctl.sample = pend_sample_ff;
      max_ctl.now    = pos_ff;
      min_ctl        = max_ctl;
      min_ctl.pop    = pend_ff & min_exp0;
   end

   swmms_chain u_max_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (max_ctl),
      .keep_max (1'b1),
      .status   (max_st)
   );

   swmms_chain u_min_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (min_ctl),
      .keep_max (1'b0),
      .status   (min_st)
   );

   // Pending item and sequence position
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         pos_ff   <= '0;
         multi_ff <= 1'b0;
      end else begin
         pend_ff <= accept | (pend_ff & ~a_done);
         if (a_done) begin
            pos_ff   <= pend_last_ff ? '0 : pos_ff + PB'(1);
            multi_ff <= ~pend_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_sample_ff <= req_ch.sample;
         pend_last_ff   <= req_ch.last_sample;
      end
   end

   // Spread stage
   assign best_in = (b_spread_ff > best_ff) ? b_spread_ff : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         best_ff    <= '0;
      end else begin
         b_valid_ff <= a_done | b_stall;
         if (b_valid_ff & ~b_stall) begin
            best_ff <= b_last_ff ? '0 : best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_done) begin
         b_last_ff   <= pend_last_ff;
         b_multi_ff  <= multi_ff;
         b_spread_ff <= max_st.head_next - min_st.head_next;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (b_valid_ff & b_last_ff & ~b_stall) | (rsp_valid_ff & ~rsp_ch.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff & b_last_ff & ~b_stall) begin
         rsp_spread_ff <= b_multi_ff ? best_in : '0;
         rsp_found_ff  <= b_multi_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.max_spread = rsp_spread_ff;
   assign rsp_ch.found      = rsp_found_ff;

`ifndef ASSERT_OFF
   // With no item in hand both rows hold the newest sample, or both are empty
   a_front_pair: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> (max_st.first.valid == min_st.first.valid))
      else $error("row fronts disagree on occupancy");

   // Window maximum never lies below the window minimum
   a_front_order: assert property (@(posedge clock) disable iff (reset)
      (max_st.first.valid && min_st.first.valid)
         |-> (max_st.first.value >= min_st.first.value))
      else $error("max front below min front");

   // A finished last sample restarts the sequence
   a_seq_restart: assert property (@(posedge clock) disable iff (reset)
      (a_done && pend_last_ff) |=> (pos_ff == '0 && !multi_ff && !max_st.first.valid))
      else $error("sequence not cleared after last sample");

   // An item left waiting on a retirement pass pushes into neither row
   a_no_push_deep: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && deep) |-> !max_ctl.push && !min_ctl.push)
      else $error("push during extra retirement cycle");
`endif

endmodule

[sv/swmms_cell.sv]
module swmms_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  swmms_pkg::cell_ctl_type   ctl,
   input  logic                      keep_max,
   input  swmms_pkg::entry_type      right,
   input  logic                      left_kept,
   output swmms_pkg::entry_type      cur,
   output logic                      kept
);

   swmms_pkg::entry_type cur_ff;
   swmms_pkg::entry_type cur_in;
   swmms_pkg::entry_type shifted;
   logic                 dominated;

   // View of the row after an optional pop from the front
   assign shifted   = ctl.pop ? right : cur_ff;
   assign dominated = keep_max ? (shifted.value <= ctl.sample)
                               : (shifted.value >= ctl.sample);
   assign kept      = shifted.valid & ~dominated;

   // Next content: keep, take the new sample at the end of the kept run, or empty
   always_comb begin
      cur_in = cur_ff;
      if (ctl.clear) begin
         cur_in.valid = 1'b0;
      end else if (ctl.push) begin
         if (kept) begin
            cur_in = shifted;
         end else if (left_kept) begin
            cur_in.valid = 1'b1;
            cur_in.value = ctl.sample;
            cur_in.pos   = ctl.now;
         end else begin
            cur_in.valid = 1'b0;
         end
      end else if (ctl.pop) begin
         cur_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.valid <= 1'b0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   assign cur = cur_ff;

endmodule

[sv/swmms_chain.sv]
module swmms_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  swmms_pkg::cell_ctl_type       ctl,
   input  logic                          keep_max,
   output swmms_pkg::chain_status_type   status
);

   swmms_pkg::entry_type              cur [swmms_pkg::MAX_WINDOW];
   logic [swmms_pkg::MAX_WINDOW-1:0]  kept;
   swmms_pkg::entry_type              head_shifted;

   // Row of cells, front at index zero
   for (genvar i = 0; i < swmms_pkg::MAX_WINDOW; i++) begin : g_cell
      swmms_pkg::entry_type right;
      logic                 left_kept;

      if (i == swmms_pkg::MAX_WINDOW - 1) begin : g_tail
         assign right = '0;
      end else begin : g_mid
         assign right = cur[i+1];
      end

      if (i == 0) begin : g_head
         assign left_kept = 1'b1;
      end else begin : g_body
         assign left_kept = kept[i-1];
      end

      swmms_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .keep_max  (keep_max),
         .right     (right),
         .left_kept (left_kept),
         .cur       (cur[i]),
         .kept      (kept[i])
      );
   end

   // Front value after this cycle's update
   assign head_shifted     = ctl.pop ? cur[1] : cur[0];
   assign status.first     = cur[0];
   assign status.second    = cur[1];
   assign status.head_next = kept[0] ? head_shifted.value : ctl.sample;

endmodule

[tb/tb_sliding_window_max_spread.sv]
module tb_sliding_window_max_spread;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [swmms_pkg::SAMPLE_BITS-1:0] sample_type;

   // one candidate of a monotonic queue: value and the position it arrived at
   typedef struct {
      sample_type  value;
      int unsigned pos;
   } cand_type;

   typedef struct {
      sample_type max_spread;
      logic       found;
   } spread_result_type;

   // Tracks the window extremes of the running sequence and the spreads still due
   class spread_scoreboard;
      logic [swmms_pkg::CFG_BITS-1:0] win_reg;
      cand_type                       hi_q[$];
      cand_type                       lo_q[$];
      int unsigned                    next_pos;
      sample_type                     best;
      bit                             multi;
      spread_result_type              due_spreads[$];
      int                             errors;

      function new();
         win_reg = swmms_pkg::CFG_RESET;
         errors  = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         hi_q.delete();
         lo_q.delete();
         next_pos = 0;
         best     = '0;
         multi    = 1'b0;
      endfunction

      function void set_window(logic [swmms_pkg::CFG_BITS-1:0] w);
         win_reg = w;
      endfunction

      function int pending();
         return due_spreads.size();
      endfunction

      // Advance the window by one item; a last sample queues its spread
      function void note_sample(sample_type value, logic is_last);
         int unsigned       span;
         int unsigned       now;
         sample_type        spread;
         spread_result_type res;
         // zero acts as one, anything past the capacity saturates
         if (win_reg == 0)
            span = 1;
         else if (win_reg > swmms_pkg::MAX_WINDOW)
            span = swmms_pkg::MAX_WINDOW;
         else
            span = win_reg;
         now = next_pos;
         if (hi_q.size() > 0)
            multi = 1'b1;
         // retire candidates that have aged out of the window
         while (hi_q.size() > 0 && now - hi_q[0].pos >= span)
            void'(hi_q.pop_front());
         while (lo_q.size() > 0 && now - lo_q[0].pos >= span)
            void'(lo_q.pop_front());
         // drop dominated candidates (ties included), then append
         while (hi_q.size() > 0 && hi_q[$].value <= value)
            void'(hi_q.pop_back());
         hi_q = {hi_q, cand_type'{value, now}};
         while (lo_q.size() > 0 && lo_q[$].value >= value)
            void'(lo_q.pop_back());
         lo_q = {lo_q, cand_type'{value, now}};
         spread = hi_q[0].value - lo_q[0].value;
         if (spread > best)
            best = spread;
         next_pos = now + 1;
         if (is_last) begin
            res.max_spread = multi ? best : '0;
            res.found      = multi;
            due_spreads    = {due_spreads, res};
            clear_sequence();
         end
      endfunction

      task check_result(sample_type max_spread, logic found);
         spread_result_type want;
         if (due_spreads.size() == 0) begin
            report($sformatf("unexpected result max_spread=%h found=%b", max_spread, found));
            return;
         end
         want = due_spreads.pop_front();
         if (max_spread !== want.max_spread)
            report($sformatf("max_spread %h, expected %h", max_spread, want.max_spread));
         if (found !== want.found)
            report($sformatf("found %b, expected %b", found, want.found));
      endtask

      task report(string msg);
         $display("MISMATCH at %0t ns: %s", $time, msg);
         errors++;
      endtask
   endclass

   logic clock;
   logic reset;
   bit   gaps_on = 1'b1;

   swmms_req_if req_bus();
   swmms_rsp_if rsp_bus();
   swmms_csr_if csr_bus();

   spread_scoreboard board = new();

   sliding_window_max_spread uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side: random back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= gaps_on ? ($urandom_range(99) >= 21) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result(rsp_bus.max_spread, rsp_bus.found);
   end

   initial begin
      #5ms;
      $display("sliding_window_max_spread test failed");
      $finish;
   end

   // Offer one sample; called and returning at a falling edge, valid left high
   task automatic push_sample(input sample_type value, input logic is_last);
      while (gaps_on && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.sample      <= value;
      req_bus.last_sample <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      board.note_sample(value, is_last);
      @(negedge clock);
   endtask

   // Register write once every spread is in and the pipeline has drained
   task automatic write_window(input logic [swmms_pkg::CFG_BITS-1:0] w);
      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.window_length <= w;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_window(w);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_list(input sample_type vals[$], input bit closes);
      foreach (vals[i])
         push_sample(vals[i], closes && i == vals.size() - 1);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return sample_type'($urandom_range(3));
         4:       return 32'h8000_0000 + sample_type'($urandom_range(15));
         default: return sample_type'($urandom);
      endcase
   endfunction

   initial begin
      int          phase_w[11] = '{3, 1024, 1, 17, 2047, 0, 600, 2, 5, 1300, 64};
      int          budget;
      int unsigned seq_left;
      bit          ramp_on;
      bit          long_done;
      sample_type  ramp;
      sample_type  value;
      int          r;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.sample        = '0;
      req_bus.last_sample   = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.window_length = '0;
      seq_left              = 0;
      ramp_on               = 1'b0;
      long_done             = 1'b0;
      ramp                  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset window of two: lone sample, full-range pair, equal values
      send_list({32'd5}, 1'b1);
      send_list({32'h0000_0000, 32'hFFFF_FFFF}, 1'b1);
      send_list({32'd7, 32'd7, 32'd7}, 1'b1);
      // window of one, and zero which acts as one
      write_window(11'd1);
      send_list({32'h0000_0000, 32'hFFFF_FFFF, 32'd7}, 1'b1);
      write_window(11'd0);
      send_list({32'hFFFF_FFFF, 32'h0000_0000}, 1'b1);
      // oversized length saturates
      write_window(11'd2047);
      send_list({32'd3, 32'd3, 32'd9, 32'd1, 32'd4}, 1'b1);
      // shrink in the middle of a sequence
      write_window(11'd3);
      send_list({32'd10, 32'd1, 32'd50}, 1'b0);
      write_window(11'd2);
      send_list({32'd20, 32'd5}, 1'b1);

      // random phases; a sequence may run across a length change
      for (int p = 0; p < 11; p++) begin
         write_window(swmms_pkg::CFG_BITS'(phase_w[p]));
         gaps_on = (p != 3);
         budget  = (p == 1) ? 1060 : 50;
         for (int n = 0; n < budget; n++) begin
            if (seq_left == 0) begin
               ramp_on = 1'b0;
               if (p == 1 && !long_done) begin
                  // falling ramp fills the max queue to the full window
                  seq_left  = 1100;
                  ramp_on   = 1'b1;
                  long_done = 1'b1;
                  ramp      = 32'hFFFF_FFFF - sample_type'($urandom_range(65535));
               end else begin
                  r = $urandom_range(99);
                  if (r < 15)
                     seq_left = 1;
                  else if (r < 75)
                     seq_left = $urandom_range(2, 12);
                  else
                     seq_left = $urandom_range(13, 40);
               end
            end
            if (ramp_on) begin
               value = ramp;
               ramp  = ramp - sample_type'($urandom_range(4000));
            end else begin
               value = pick_sample();
            end
            seq_left--;
            push_sample(value, seq_left == 0);
         end
      end
      gaps_on = 1'b1;
      while (seq_left != 0) begin
         seq_left--;
         push_sample(pick_sample(), seq_left == 0);
      end

      // drain
      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (board.errors == 0)
         $display("sliding_window_max_spread test passed");
      else
         $display("sliding_window_max_spread test failed");
      $finish;
   end

endmodule
